@@ rtl/tsw_pkg.sv @@
// Package for the tagged section walker: phase codes, status codes, result record,
// known tag words and the tag classifier. No dependencies.
`default_nettype none

package tsw_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned FIFO_PTR_BITS     = 2;

  localparam logic [31:0] MAGIC_WORD     = 32'h504D_4149;
  localparam logic [31:0] FALLBACK_HDR   = 32'h0000_001C;
  localparam logic [31:0] PROLOGUE_BYTES = 32'd12;

  typedef enum logic [2:0] {
    PH_MAGIC    = 3'd0,
    PH_HLEN     = 3'd1,
    PH_SKIP     = 3'd2,
    PH_PROLOGUE = 3'd3,
    PH_DONE     = 3'd4
  } phase_e;

  localparam logic       KIND_SECTION = 1'b0;
  localparam logic       KIND_DONE    = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] tag;
    logic [3:0]  cls;
    logic [31:0] offset;
    logic [31:0] length;
    logic        last;
  } result_t;

  localparam logic [31:0] TAG_PQTZ = 32'h5051_545A;
  localparam logic [31:0] TAG_PCOB = 32'h5043_4F42;
  localparam logic [31:0] TAG_PCO2 = 32'h5043_4F32;
  localparam logic [31:0] TAG_PPTH = 32'h5050_5448;
  localparam logic [31:0] TAG_PWAV = 32'h5057_4156;
  localparam logic [31:0] TAG_PWV3 = 32'h5057_5633;
  localparam logic [31:0] TAG_PWV4 = 32'h5057_5634;
  localparam logic [31:0] TAG_PWV5 = 32'h5057_5635;
  localparam logic [31:0] TAG_PWV6 = 32'h5057_5636;
  localparam logic [31:0] TAG_PWV7 = 32'h5057_5637;
  localparam logic [31:0] TAG_PSSI = 32'h5053_5349;

  function automatic logic [3:0] tag_class(input logic [31:0] tag);
    logic [3:0] cls;
    cls = 4'd0;
    case (tag)
      TAG_PQTZ: cls = 4'd1;
      TAG_PCOB: cls = 4'd2;
      TAG_PCO2: cls = 4'd3;
      TAG_PPTH: cls = 4'd4;
      TAG_PWAV: cls = 4'd5;
      TAG_PWV3: cls = 4'd6;
      TAG_PWV4: cls = 4'd7;
      TAG_PWV5: cls = 4'd8;
      TAG_PWV6: cls = 4'd9;
      TAG_PWV7: cls = 4'd10;
      TAG_PSSI: cls = 4'd11;
      default:  cls = 4'd0;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tagged_section_walker.sv @@
// Tagged section walker: byte-serial container walker, 4-entry result queue.
// Each result is written into the registered result queue on its byte's transfer.
// Throughput: one byte per cycle; a byte that yields two results writes both at once,
// and the input stalls while the result queue holds more than two entries.
// Reset (rst_ni low, asynchronous) clears walk state, the queue and file_length.
// Depends on tsw_pkg.
`default_nettype none

module tagged_section_walker #(
  parameter int unsigned POSITION_BITS = tsw_pkg::POSITION_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [1:0]       walk_status_o,
  output logic [31:0]      tag_value_o,
  output logic [3:0]       tag_class_o,
  output logic [31:0]      body_offset_o,
  output logic [31:0]      body_length_o,
  output logic             last_of_run_o
);

  localparam int unsigned CW  = (POSITION_BITS > 34) ? POSITION_BITS : 34;
  localparam int unsigned PTR = tsw_pkg::FIFO_PTR_BITS;
  localparam int unsigned CNT = PTR + 1;

  // ---------------- configuration ----------------
  logic [31:0] flen_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : flen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q <= 32'd0;
    end else if (cfg_wr) begin
      flen_q <= pwdata;
    end
  end

  // ---------------- walk state ----------------
  tsw_pkg::phase_e            phase_q, phase_d;
  logic [POSITION_BITS-1:0]   pos_q, pos_d;
  logic [31:0]                shift_q, shift_d;
  logic [31:0]                tag_q, tag_d;
  logic [32:0]                sec_q, sec_d;

  tsw_pkg::result_t           res_a, res_b;
  logic                       a_v, b_v;
  logic                       in_xfer, out_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  always_comb begin
    logic [31:0]            shift_nx;
    logic [31:0]            hdr;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [CW-1:0]          pos_w;
    logic [CW-1:0]          sec_w;
    logic [33:0]            sum;
    tsw_pkg::result_t       fin_res;

    shift_nx = {shift_q[23:0], data_byte_i};
    pos_inc  = pos_q + POSITION_BITS'(1);
    pos_w    = CW'(pos_q);
    sec_w    = CW'(sec_q);
    hdr      = 32'd0;
    sum      = 34'd0;

    fin_res        = '0;
    fin_res.kind   = tsw_pkg::KIND_DONE;

    phase_d = phase_q;
    pos_d   = pos_inc;
    shift_d = shift_q;
    tag_d   = tag_q;
    sec_d   = sec_q;
    res_a   = fin_res;
    res_b   = fin_res;
    a_v     = 1'b0;
    b_v     = 1'b0;

    case (phase_q)
      tsw_pkg::PH_MAGIC: begin
        if (pos_q == '0 && flen_q < tsw_pkg::PROLOGUE_BYTES) begin
          a_v          = 1'b1;
          res_a.status = tsw_pkg::ST_SHORT;
          phase_d      = tsw_pkg::PH_DONE;
        end else begin
          shift_d = shift_nx;
          if (pos_q == POSITION_BITS'(3)) begin
            if (shift_nx != tsw_pkg::MAGIC_WORD) begin
              a_v          = 1'b1;
              res_a.status = tsw_pkg::ST_BAD_MAGIC;
              phase_d      = tsw_pkg::PH_DONE;
            end else begin
              phase_d = tsw_pkg::PH_HLEN;
            end
          end
        end
      end
      tsw_pkg::PH_HLEN: begin
        shift_d = shift_nx;
        if (pos_q == POSITION_BITS'(7)) begin
          hdr = shift_nx;
          if (hdr < tsw_pkg::PROLOGUE_BYTES || hdr > flen_q) hdr = tsw_pkg::FALLBACK_HDR;
          if (hdr > flen_q) begin
            a_v          = 1'b1;
            res_a.status = tsw_pkg::ST_SHORT;
            phase_d      = tsw_pkg::PH_DONE;
          end else if ({1'b0, hdr} + {1'b0, tsw_pkg::PROLOGUE_BYTES} > {1'b0, flen_q}) begin
            a_v          = 1'b1;
            res_a.status = tsw_pkg::ST_OK;
            phase_d      = tsw_pkg::PH_DONE;
          end else begin
            sec_d   = {1'b0, hdr};
            phase_d = tsw_pkg::PH_SKIP;
          end
        end
      end
      tsw_pkg::PH_SKIP: begin
        if (CW'(pos_inc) == sec_w) phase_d = tsw_pkg::PH_PROLOGUE;
      end
      tsw_pkg::PH_PROLOGUE: begin
        shift_d = shift_nx;
        if (pos_w == sec_w + CW'(3)) tag_d = shift_nx;
        if (pos_w == sec_w + CW'(11)) begin
          sum = {1'b0, sec_q} + {2'b00, shift_nx};
          if (shift_nx < tsw_pkg::PROLOGUE_BYTES || sum > {2'b00, flen_q}) begin
            a_v          = 1'b1;
            res_a.status = tsw_pkg::ST_OK;
            phase_d      = tsw_pkg::PH_DONE;
          end else begin
            a_v          = 1'b1;
            res_a.kind   = tsw_pkg::KIND_SECTION;
            res_a.status = tsw_pkg::ST_OK;
            res_a.tag    = tag_q;
            res_a.cls    = tsw_pkg::tag_class(tag_q);
            res_a.offset = sec_q[31:0] + tsw_pkg::PROLOGUE_BYTES;
            res_a.length = shift_nx - tsw_pkg::PROLOGUE_BYTES;
            sec_d        = sum[32:0];
            if (sum + 34'(tsw_pkg::PROLOGUE_BYTES) > {2'b00, flen_q}) begin
              b_v          = 1'b1;
              res_b.status = tsw_pkg::ST_OK;
              phase_d      = tsw_pkg::PH_DONE;
            end else if (shift_nx == tsw_pkg::PROLOGUE_BYTES) begin
              phase_d = tsw_pkg::PH_PROLOGUE;
            end else begin
              phase_d = tsw_pkg::PH_SKIP;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (final_byte_i) begin
      // early last byte: append a too-short finish unless the walk already ended
      if (phase_d != tsw_pkg::PH_DONE) begin
        if (a_v) begin
          b_v          = 1'b1;
          res_b.status = tsw_pkg::ST_SHORT;
        end else begin
          a_v          = 1'b1;
          res_a.status = tsw_pkg::ST_SHORT;
        end
      end
      phase_d = tsw_pkg::PH_MAGIC;
      pos_d   = '0;
      shift_d = 32'd0;
      tag_d   = 32'd0;
      sec_d   = 33'd0;
    end

    res_a.last = !b_v;
    res_b.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tsw_pkg::PH_MAGIC;
      pos_q   <= '0;
      shift_q <= 32'd0;
      tag_q   <= 32'd0;
      sec_q   <= 33'd0;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      tag_q   <= tag_d;
      sec_q   <= sec_d;
    end
  end

  // ---------------- result queue ----------------
  tsw_pkg::result_t fifo_q [tsw_pkg::FIFO_DEPTH];
  logic [PTR-1:0]   wptr_q, rptr_q;
  logic [CNT-1:0]   count_q;
  logic [CNT-1:0]   push_n;

  assign out_valid_o = (count_q != '0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign in_ready_o  = (count_q <= CNT'(tsw_pkg::FIFO_DEPTH - 2));
  assign push_n      = in_xfer ? (CNT'(a_v) + CNT'(b_v)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + push_n[PTR-1:0];
      rptr_q  <= rptr_q + PTR'(out_xfer);
      count_q <= count_q + push_n - CNT'(out_xfer);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && a_v) fifo_q[wptr_q] <= res_a;
    if (in_xfer && b_v) fifo_q[wptr_q + PTR'(1)] <= res_b;
  end

  assign result_kind_o = fifo_q[rptr_q].kind;
  assign walk_status_o = fifo_q[rptr_q].status;
  assign tag_value_o   = fifo_q[rptr_q].tag;
  assign tag_class_o   = fifo_q[rptr_q].cls;
  assign body_offset_o = fifo_q[rptr_q].offset;
  assign body_length_o = fifo_q[rptr_q].length;
  assign last_of_run_o = fifo_q[rptr_q].last;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT'(tsw_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_final_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && final_byte_i) |=> (phase_q == tsw_pkg::PH_MAGIC && pos_q == '0))
    else $error("walker did not restart after last byte");

  a_magic_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tsw_pkg::PH_MAGIC) |-> (pos_q < POSITION_BITS'(4)))
    else $error("magic phase past byte 3");

  a_hlen_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tsw_pkg::PH_HLEN) |->
      (pos_q >= POSITION_BITS'(4) && pos_q < POSITION_BITS'(8)))
    else $error("header length phase out of bytes 4..7");

endmodule

`default_nettype wire
